// File: src/double_ended_queue_top_defines.svh
// ----------------------------------------------------------------------------
// double_ended_queue_top_defines.svh
// Assertion macros for the double-ended queue.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// Check a same-cycle implication, disabled during reset
`define DQ_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deque check failed");

// Check a next-cycle implication, disabled during reset
`define DQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

// File: src/dq_pkg.sv
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants of the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OCC_W  = 5;

  // Value reported for front and rear when the queue is empty
  localparam logic [DATA_W-1:0] EMPTY_MARK = '1;

  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_BACK   = 2'd2,
    OP_POP_FRONT  = 2'd3
  } op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_e;

endpackage

// File: src/dq_in_if.sv
// ----------------------------------------------------------------------------
// dq_in_if
// Operation channel: one queue operation per item.
// ----------------------------------------------------------------------------
interface dq_in_if;
  logic                             valid;
  logic                             ready;
  dq_pkg::op_e                      op;
  logic signed [dq_pkg::DATA_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

// File: src/dq_out_if.sv
// ----------------------------------------------------------------------------
// dq_out_if
// Result channel: queue status after each operation.
// ----------------------------------------------------------------------------
interface dq_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [dq_pkg::DATA_W-1:0] front_value;
  logic signed [dq_pkg::DATA_W-1:0] rear_value;
  logic                             is_empty;
  logic        [dq_pkg::OCC_W-1:0]  occupancy;
  logic                             refused;

  modport source (output valid, output front_value, output rear_value, output is_empty,
                  output occupancy, output refused, input ready);
  modport sink   (input valid, input front_value, input rear_value, input is_empty,
                  input occupancy, input refused, output ready);
endinterface

// File: src/dq_ram.sv
// ----------------------------------------------------------------------------
// dq_ram
// Slot storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4,
  parameter int unsigned W     = 32
) (
  input  logic          clk_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [W-1:0]  wr_data_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [W-1:0]  rd_data_o
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rd_data_q;

  // Write one slot
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read one slot, data valid next cycle
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: src/double_ended_queue_top.sv
// Result: pushes, refused ops and pops that empty the queue load the result register when
//   accepted; a pop that leaves entries first reads the slot memory (registered read data).
// Throughput: 1 item per cycle for pushes while the result sink keeps up; after such a pop
//   no new item is taken until the slot read has been reported from the read state.
// Reset: asynchronous active low clears head index, count, state and result valid;
//   the slot memory is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Double-ended queue over a circular slot memory with head index and count.
// ----------------------------------------------------------------------------
`include "double_ended_queue_top_defines.svh"

module double_ended_queue_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  dq_in_if.sink    in_i,
  dq_out_if.source out_o
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned DW = dq_pkg::DATA_W;
  localparam int unsigned OW = dq_pkg::OCC_W;

  localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
  localparam logic [CW-1:0] CAP_C    = CW'(CAPACITY);
  localparam logic [SW-1:0] CAP_S    = SW'(CAPACITY);

  dq_pkg::state_e state_q, state_d;
  logic [IW-1:0]  head_q, head_d;
  logic [CW-1:0]  count_q, count_d;
  logic [DW-1:0]  front_q, front_d;
  logic [DW-1:0]  rear_q, rear_d;
  logic           pend_front_q, pend_front_d;

  logic           out_valid_q, out_valid_d;
  logic [DW-1:0]  out_front_q, out_front_d;
  logic [DW-1:0]  out_rear_q, out_rear_d;
  logic           out_empty_q, out_empty_d;
  logic [OW-1:0]  out_occ_q, out_occ_d;
  logic           out_ref_q, out_ref_d;

  logic           in_ready;
  logic           in_fire;
  logic           q_full;
  logic           q_empty;
  logic [SW-1:0]  tail_sum;
  logic [SW-1:0]  rear2_sum;
  logic [IW-1:0]  tail_idx;
  logic [IW-1:0]  rear2_idx;
  logic [IW-1:0]  head_inc;
  logic [IW-1:0]  head_dec;
  logic           refused;
  logic [CW+OW-1:0] occ_ext;

  logic           wr_en;
  logic [IW-1:0]  wr_addr;
  logic [IW-1:0]  rd_addr;
  logic [DW-1:0]  rd_data;

  // Slot storage
  dq_ram #(
    .DEPTH (CAPACITY),
    .AW    (IW),
    .W     (DW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (in_i.value),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // Take an item when idle and the result register frees up
  assign in_ready   = (state_q == dq_pkg::ST_IDLE) && (!out_valid_q || out_o.ready);
  assign in_i.ready = in_ready;
  assign in_fire    = in_i.valid && in_ready;

  // Index arithmetic around the ring
  assign q_full    = (count_q == CAP_C);
  assign q_empty   = (count_q == '0);
  assign tail_sum  = SW'(head_q) + SW'(count_q);
  assign rear2_sum = tail_sum - SW'(2);
  assign tail_idx  = (tail_sum >= CAP_S) ? IW'(tail_sum - CAP_S) : IW'(tail_sum);
  assign rear2_idx = (rear2_sum >= CAP_S) ? IW'(rear2_sum - CAP_S) : IW'(rear2_sum);
  assign head_inc  = (head_q == LAST_IDX) ? '0 : head_q + IW'(1);
  assign head_dec  = (head_q == '0) ? LAST_IDX : head_q - IW'(1);

  // Read the slot that becomes the new end after a pop
  assign rd_addr = (in_i.op == dq_pkg::OP_POP_BACK) ? rear2_idx : head_inc;

  // Low bits of the count for the occupancy field
  assign occ_ext = {{OW{1'b0}}, count_d};

  // Next state, slot write and result load
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    count_d      = count_q;
    front_d      = front_q;
    rear_d       = rear_q;
    pend_front_d = pend_front_q;
    wr_en        = 1'b0;
    wr_addr      = tail_idx;
    refused      = 1'b0;

    out_valid_d  = out_valid_q && !out_o.ready;
    out_front_d  = out_front_q;
    out_rear_d   = out_rear_q;
    out_empty_d  = out_empty_q;
    out_occ_d    = out_occ_q;
    out_ref_d    = out_ref_q;

    case (state_q)
      dq_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_i.op)
            dq_pkg::OP_PUSH_BACK: begin
              if (q_full) begin
                refused = 1'b1;
              end else begin
                wr_en   = 1'b1;
                wr_addr = tail_idx;
                count_d = count_q + CW'(1);
                rear_d  = in_i.value;
                if (q_empty) begin
                  front_d = in_i.value;
                end
              end
            end
            dq_pkg::OP_PUSH_FRONT: begin
              if (q_full) begin
                refused = 1'b1;
              end else begin
                wr_en   = 1'b1;
                wr_addr = head_dec;
                head_d  = head_dec;
                count_d = count_q + CW'(1);
                front_d = in_i.value;
                if (q_empty) begin
                  rear_d = in_i.value;
                end
              end
            end
            dq_pkg::OP_POP_BACK: begin
              if (q_empty) begin
                refused = 1'b1;
              end else begin
                count_d = count_q - CW'(1);
                if (count_q > CW'(1)) begin
                  state_d      = dq_pkg::ST_READ;
                  pend_front_d = 1'b0;
                end
              end
            end
            default: begin
              if (q_empty) begin
                refused = 1'b1;
              end else begin
                head_d  = head_inc;
                count_d = count_q - CW'(1);
                if (count_q > CW'(1)) begin
                  state_d      = dq_pkg::ST_READ;
                  pend_front_d = 1'b1;
                end
              end
            end
          endcase
          // Load the result now unless a slot read is outstanding
          if (state_d == dq_pkg::ST_IDLE) begin
            out_valid_d = 1'b1;
            out_front_d = (count_d == '0) ? dq_pkg::EMPTY_MARK : front_d;
            out_rear_d  = (count_d == '0) ? dq_pkg::EMPTY_MARK : rear_d;
            out_empty_d = (count_d == '0);
            out_occ_d   = occ_ext[OW-1:0];
            out_ref_d   = refused;
          end
        end
      end
      dq_pkg::ST_READ: begin
        // Fill the new end from the slot read and report
        if (pend_front_q) begin
          front_d = rd_data;
        end else begin
          rear_d = rd_data;
        end
        state_d     = dq_pkg::ST_IDLE;
        out_valid_d = 1'b1;
        out_front_d = front_d;
        out_rear_d  = rear_d;
        out_empty_d = 1'b0;
        out_occ_d   = occ_ext[OW-1:0];
        out_ref_d   = 1'b0;
      end
      default: begin
        state_d = dq_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dq_pkg::ST_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    front_q      <= front_d;
    rear_q       <= rear_d;
    pend_front_q <= pend_front_d;
    out_front_q  <= out_front_d;
    out_rear_q   <= out_rear_d;
    out_empty_q  <= out_empty_d;
    out_occ_q    <= out_occ_d;
    out_ref_q    <= out_ref_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.front_value = $signed(out_front_q);
  assign out_o.rear_value  = $signed(out_rear_q);
  assign out_o.is_empty    = out_empty_q;
  assign out_o.occupancy   = out_occ_q;
  assign out_o.refused     = out_ref_q;

  // Checks
  `DQ_ASSERT_SAME(a_count_in_range, 1'b1, count_q <= CAP_C)
  `DQ_ASSERT_SAME(a_read_out_free, state_q == dq_pkg::ST_READ, !out_valid_q && count_q != '0)
  `DQ_ASSERT_NEXT(a_read_reports, state_q == dq_pkg::ST_READ,
                  state_q == dq_pkg::ST_IDLE && out_valid_q)

endmodule

// File: sim/double_ended_queue_checker.sv
// ----------------------------------------------------------------------------
// double_ended_queue_checker
// Watches the operation and status channels of the double-ended queue. It
// keeps its own circular buffer, head index and entry count, predicts the
// status after every accepted operation, and compares each accepted status
// with the oldest prediction.
// ----------------------------------------------------------------------------
module double_ended_queue_checker #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dq_in_if            op_i,
  dq_out_if           res_i,
  output int unsigned mismatch_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic signed [dq_pkg::DATA_W-1:0] front_value;
    logic signed [dq_pkg::DATA_W-1:0] rear_value;
    logic                             is_empty;
    logic [dq_pkg::OCC_W-1:0]         occupancy;
    logic                             refused;
  } deque_status_t;

  // Shadow copy of the queue contents
  logic [dq_pkg::DATA_W-1:0] slot_mem [CAPACITY];
  int unsigned               head_idx;
  int unsigned               entry_cnt;
  int unsigned               mismatches;
  deque_status_t             status_due [$];

  // Apply one operation to the shadow queue and return the status it leaves
  function automatic deque_status_t apply_op(dq_pkg::op_e op,
                                             logic [dq_pkg::DATA_W-1:0] value);
    deque_status_t st;
    st.refused = 1'b0;
    case (op)
      dq_pkg::OP_PUSH_BACK: begin
        if (entry_cnt >= CAPACITY) begin
          st.refused = 1'b1;
        end else begin
          slot_mem[(head_idx + entry_cnt) % CAPACITY] = value;
          entry_cnt++;
        end
      end
      dq_pkg::OP_PUSH_FRONT: begin
        if (entry_cnt >= CAPACITY) begin
          st.refused = 1'b1;
        end else begin
          head_idx = (head_idx + CAPACITY - 1) % CAPACITY;
          slot_mem[head_idx] = value;
          entry_cnt++;
        end
      end
      dq_pkg::OP_POP_BACK: begin
        if (entry_cnt == 0) begin
          st.refused = 1'b1;
        end else begin
          entry_cnt--;
        end
      end
      dq_pkg::OP_POP_FRONT: begin
        if (entry_cnt == 0) begin
          st.refused = 1'b1;
        end else begin
          head_idx = (head_idx + 1) % CAPACITY;
          entry_cnt--;
        end
      end
      default: begin
      end
    endcase
    // Report the empty mark on both ends when nothing is held
    if (entry_cnt == 0) begin
      st.front_value = dq_pkg::EMPTY_MARK;
      st.rear_value  = dq_pkg::EMPTY_MARK;
    end else begin
      st.front_value = slot_mem[head_idx];
      st.rear_value  = slot_mem[(head_idx + entry_cnt - 1) % CAPACITY];
    end
    st.is_empty  = (entry_cnt == 0);
    st.occupancy = dq_pkg::OCC_W'(entry_cnt);
    return st;
  endfunction

  // Compare accepted status items first, then record the new operation
  always @(posedge clk_i or negedge rst_ni) begin
    deque_status_t want;
    deque_status_t got;
    logic          bad;
    if (!rst_ni) begin
      status_due.delete();
      head_idx   = 0;
      entry_cnt  = 0;
      mismatches = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        got.front_value = res_i.front_value;
        got.rear_value  = res_i.rear_value;
        got.is_empty    = res_i.is_empty;
        got.occupancy   = res_i.occupancy;
        got.refused     = res_i.refused;
        if (status_due.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected status item: front=%0d rear=%0d empty=%b occ=%0d refused=%b",
                     got.front_value, got.rear_value, got.is_empty, got.occupancy,
                     got.refused);
          end
          mismatches++;
        end else begin
          // Take the oldest prediction
          want = status_due[0];
          status_due.delete(0);
          bad = (got.front_value !== want.front_value) ||
                (got.rear_value  !== want.rear_value)  ||
                (got.is_empty    !== want.is_empty)    ||
                (got.occupancy   !== want.occupancy)   ||
                (got.refused     !== want.refused);
          if (bad) begin
            if (mismatches < 10) begin
              $display("status mismatch: exp front=%0d rear=%0d empty=%b occ=%0d refused=%b",
                       want.front_value, want.rear_value, want.is_empty, want.occupancy,
                       want.refused);
              $display("                 got front=%0d rear=%0d empty=%b occ=%0d refused=%b",
                       got.front_value, got.rear_value, got.is_empty, got.occupancy,
                       got.refused);
            end
            mismatches++;
          end
        end
      end
      if (op_i.valid && op_i.ready) begin
        status_due.insert(status_due.size(), apply_op(op_i.op, op_i.value));
      end
    end
    mismatch_count_o <= mismatches;
    pending_o        <= status_due.size();
  end

endmodule

// File: sim/double_ended_queue_top_tb.sv
// ----------------------------------------------------------------------------
// double_ended_queue_top_tb
// Drives queue operations into the double-ended queue with random gaps and
// random status backpressure: a directed part for empty, full and extreme
// values, then biased random runs that swing between empty and full.
// ----------------------------------------------------------------------------
module double_ended_queue_top_tb;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned RANDOM_OPS  = 1700;
  localparam int unsigned QUIET_LIMIT = 200;

  logic        clk_i;
  logic        rst_ni;
  logic        no_gaps;
  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned quiet_cycles;

  dq_in_if  op_ch ();
  dq_out_if res_ch ();

  double_ended_queue_top #(.CAPACITY(DEPTH)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (op_ch),
    .out_o  (res_ch)
  );

  double_ended_queue_checker #(.CAPACITY(DEPTH)) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .op_i             (op_ch),
    .res_i            (res_ch),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_count)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Status sink: stall a random number of cycles before each item
  initial begin
    int unsigned stall;
    res_ch.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(res_ch.valid && res_ch.ready));
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one operation after a random gap and hold it until accepted
  task automatic issue_op(dq_pkg::op_e op, logic [dq_pkg::DATA_W-1:0] value);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      op_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    op_ch.valid <= 1'b1;
    op_ch.op    <= op;
    op_ch.value <= value;
    do @(posedge clk_i); while (!op_ch.ready);
  endtask

  // Hold off new operations until every predicted status has arrived
  task automatic wait_all_reported();
    op_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0);
  endtask

  // Stimulus
  initial begin
    dq_pkg::op_e               op;
    logic [dq_pkg::DATA_W-1:0] value;
    int unsigned               sent;
    int unsigned               seg_len;
    int unsigned               push_pct;

    rst_ni       <= 1'b0;
    op_ch.valid  <= 1'b0;
    op_ch.op     <= dq_pkg::OP_PUSH_BACK;
    op_ch.value  <= '0;
    no_gaps      = 1'b0;
    quiet_cycles = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Pops on an empty queue
    issue_op(dq_pkg::OP_POP_BACK, 32'h0000_0005);
    issue_op(dq_pkg::OP_POP_FRONT, '1);
    // Extreme values at both ends; all ones looks like the empty mark
    issue_op(dq_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFF);
    issue_op(dq_pkg::OP_PUSH_BACK, 32'h8000_0000);
    issue_op(dq_pkg::OP_PUSH_BACK, '1);
    issue_op(dq_pkg::OP_PUSH_FRONT, '0);
    // Fill up, then push into a full queue from both ends
    for (int k = 0; k < DEPTH - 4; k++) begin
      if (k[0]) begin
        issue_op(dq_pkg::OP_PUSH_FRONT, $urandom);
      end else begin
        issue_op(dq_pkg::OP_PUSH_BACK, $urandom);
      end
    end
    issue_op(dq_pkg::OP_PUSH_BACK, 32'h1234_5678);
    issue_op(dq_pkg::OP_PUSH_FRONT, 32'h8765_4321);
    issue_op(dq_pkg::OP_POP_BACK, '0);
    issue_op(dq_pkg::OP_POP_FRONT, '0);
    wait_all_reported();

    // Random runs, each biased toward pushes, pops or neither
    sent = 0;
    while (sent < RANDOM_OPS) begin
      seg_len = $urandom_range(16, 64);
      case ($urandom_range(0, 2))
        0:       push_pct = 20;
        1:       push_pct = 50;
        default: push_pct = 80;
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < seg_len && sent < RANDOM_OPS; n++) begin
        if ($urandom_range(0, 99) < push_pct) begin
          if ($urandom_range(0, 1) != 0) begin
            op = dq_pkg::OP_PUSH_FRONT;
          end else begin
            op = dq_pkg::OP_PUSH_BACK;
          end
        end else begin
          if ($urandom_range(0, 1) != 0) begin
            op = dq_pkg::OP_POP_FRONT;
          end else begin
            op = dq_pkg::OP_POP_BACK;
          end
        end
        value = $urandom;
        if ($urandom_range(0, 7) == 0) begin
          case ($urandom_range(0, 3))
            0:       value = 32'h8000_0000;
            1:       value = 32'h7FFF_FFFF;
            2:       value = '1;
            default: value = '0;
          endcase
        end
        issue_op(op, value);
        sent++;
      end
      if ($urandom_range(0, 9) == 0) begin
        wait_all_reported();
      end
    end

    // Let the last status items drain, then give the verdict
    no_gaps = 1'b0;
    wait_all_reported();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
